[rtl/imh_pkg.sv]
// package for the indexed min-heap: sizes, operation codes and item types
`default_nettype none
package imh_pkg;

    localparam int CAPACITY     = 1024;
    localparam int MAX_VERTICES = 1024;
    localparam int KEY_BITS     = 32;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int ID_W   = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    localparam logic [1:0] KIND_INSERT     = 2'd0;
    localparam logic [1:0] KIND_DELETE_MIN = 2'd1;
    localparam logic [1:0] KIND_DECREASE   = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [ID_W-1:0]     vertex_id;
        logic [KEY_BITS-1:0] key;
        logic [SLOT_W-1:0]   heap_slot;
    } imh_in_t;

    typedef struct packed {
        logic                ignored;
        logic                empty_res;
        logic [ID_W-1:0]     min_id;
        logic [KEY_BITS-1:0] min_key;
        logic [CNT_W-1:0]    count;
        logic [SLOT_W-1:0]   id_slot;
    } imh_out_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [KEY_BITS-1:0] key;
    } imh_entry_t;

endpackage
`default_nettype wire

[rtl/indexed_min_heap.sv]
// indexed binary min-heap with vertex position map, one operation per item
// Each item is an insert, a delete-min or a decrease-key (addressed by heap slot); every
// item gives exactly one result with the root, the entry count and the map slot of the
// item's vertex id. The block takes one item at a time: s_ready is high only while the
// sequencer is idle. The heap and the position map are single-write-port memories with
// registered reads, and the key comparators are reused at every heap level, so each level
// of a sift is a read, a compare with the first write, and a second write. An insert
// writes the new entry at the last slot and sifts it up; a decrease-key first reads the
// entry at its slot, then writes the new key there and sifts it up; a delete-min reads
// the root and the last entry, swaps them and sifts the new root down; ignored items go
// straight to the result. A finished result sits in an output register, so the next
// item is taken while it waits; that item's result then waits in the sequencer until
// the earlier one is taken.
`default_nettype none
module indexed_min_heap
    import imh_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire imh_in_t  s_item,
    output logic          m_valid,
    input  wire logic     m_ready,
    output imh_out_t      m_item
);

    localparam int WIDE = SLOT_W + 2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INS_WR, ST_DEC_RD, ST_DEC_WR, ST_DEL_RD, ST_DEL_WR0, ST_DEL_WR1,
        ST_UP_RD, ST_UP_SW, ST_UP_WR1, ST_DN_RD, ST_DN_SW, ST_DN_WR1, ST_FIN_RD, ST_FIN_OUT
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    imh_in_t           in_reg;
    imh_entry_t        cur_reg;
    imh_entry_t        oth_reg;
    logic [SLOT_W-1:0] j_reg;
    logic [SLOT_W-1:0] nxt_reg;
    logic              ign_reg;
    logic              m_valid_reg;
    imh_out_t          m_item_reg;

    imh_entry_t        heap_mem [CAPACITY];
    logic [SLOT_W-1:0] map_mem  [MAX_VERTICES];
    imh_entry_t        hp_rd0_reg;
    imh_entry_t        hp_rd1_reg;
    logic [SLOT_W-1:0] mp_rd_reg;

    logic              hp_we;
    logic [SLOT_W-1:0] hp_wa;
    imh_entry_t        hp_wd;
    logic              mp_we;
    logic [ID_W-1:0]   mp_wa;
    logic [SLOT_W-1:0] mp_wd;
    logic              hp_re;
    logic [SLOT_W-1:0] hp_ra0;
    logic [SLOT_W-1:0] hp_ra1;
    logic              mp_re;

    logic [SLOT_W-1:0] up_par;
    logic [SLOT_W:0]   dn_c1;
    logic [SLOT_W:0]   dn_c2;
    logic              dn_has_c1;
    logic              dn_has_c2;
    logic              dn_sel2;
    imh_entry_t        dn_child;
    logic [SLOT_W-1:0] dn_caddr;
    logic              up_swap;
    logic              dn_swap;
    logic [SLOT_W-1:0] last_slot;
    logic              out_free;

    assign up_par    = (j_reg - SLOT_W'(1)) >> 1;
    assign dn_c1     = {j_reg, 1'b1};
    assign dn_c2     = dn_c1 + (SLOT_W + 1)'(1);
    assign dn_has_c1 = WIDE'(dn_c1) < WIDE'(cnt_reg);
    assign dn_has_c2 = WIDE'(dn_c2) < WIDE'(cnt_reg);
    assign dn_sel2   = dn_has_c2 && (hp_rd1_reg.key < hp_rd0_reg.key);
    assign dn_child  = dn_sel2 ? hp_rd1_reg : hp_rd0_reg;
    assign dn_caddr  = dn_sel2 ? dn_c2[SLOT_W-1:0] : dn_c1[SLOT_W-1:0];
    assign up_swap   = cur_reg.key < hp_rd0_reg.key;
    assign dn_swap   = !(cur_reg.key < dn_child.key);
    assign last_slot = cnt_reg[SLOT_W-1:0];
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // memory port control
    always_comb begin
        hp_we  = 1'b0;
        hp_wa  = '0;
        hp_wd  = cur_reg;
        mp_we  = 1'b0;
        mp_wa  = cur_reg.id;
        mp_wd  = '0;
        hp_re  = 1'b0;
        hp_ra0 = '0;
        hp_ra1 = '0;
        mp_re  = 1'b0;
        case (state_reg)
            ST_INS_WR: begin
                hp_we = 1'b1;
                hp_wa = last_slot;
                hp_wd = '{id: in_reg.vertex_id, key: in_reg.key};
                mp_we = 1'b1;
                mp_wa = in_reg.vertex_id;
                mp_wd = last_slot;
            end
            ST_DEC_RD: begin
                hp_re  = 1'b1;
                hp_ra0 = in_reg.heap_slot;
            end
            ST_DEC_WR: begin
                hp_we = 1'b1;
                hp_wa = in_reg.heap_slot;
                hp_wd = '{id: hp_rd0_reg.id, key: in_reg.key};
            end
            ST_DEL_RD: begin
                hp_re  = 1'b1;
                hp_ra0 = '0;
                hp_ra1 = SLOT_W'(cnt_reg - CNT_W'(1));
            end
            ST_DEL_WR0: begin
                hp_we = 1'b1;
                hp_wa = last_slot;
                hp_wd = hp_rd0_reg;
                mp_we = 1'b1;
                mp_wa = hp_rd0_reg.id;
                mp_wd = last_slot;
            end
            ST_DEL_WR1: begin
                hp_we = 1'b1;
                hp_wa = '0;
                hp_wd = hp_rd1_reg;
                mp_we = 1'b1;
                mp_wa = hp_rd1_reg.id;
                mp_wd = '0;
            end
            ST_UP_RD: begin
                hp_re  = 1'b1;
                hp_ra0 = up_par;
            end
            ST_UP_SW: begin
                hp_we = up_swap;
                hp_wa = up_par;
                hp_wd = cur_reg;
                mp_we = up_swap;
                mp_wa = cur_reg.id;
                mp_wd = up_par;
            end
            ST_UP_WR1, ST_DN_WR1: begin
                hp_we = 1'b1;
                hp_wa = j_reg;
                hp_wd = oth_reg;
                mp_we = 1'b1;
                mp_wa = oth_reg.id;
                mp_wd = j_reg;
            end
            ST_DN_RD: begin
                hp_re  = dn_has_c1;
                hp_ra0 = dn_c1[SLOT_W-1:0];
                hp_ra1 = dn_c2[SLOT_W-1:0];
            end
            ST_DN_SW: begin
                hp_we = dn_swap;
                hp_wa = dn_caddr;
                hp_wd = cur_reg;
                mp_we = dn_swap;
                mp_wa = cur_reg.id;
                mp_wd = dn_caddr;
            end
            ST_FIN_RD: begin
                hp_re  = 1'b1;
                hp_ra0 = '0;
                mp_re  = 1'b1;
            end
            default: begin
                hp_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (hp_we) begin
            heap_mem[hp_wa] <= hp_wd;
        end
        if (hp_re) begin
            hp_rd0_reg <= heap_mem[hp_ra0];
            hp_rd1_reg <= heap_mem[hp_ra1];
        end
    end

    always_ff @(posedge aclk) begin
        if (mp_we) begin
            map_mem[mp_wa] <= mp_wd;
        end
        if (mp_re) begin
            mp_rd_reg <= map_mem[in_reg.vertex_id];
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_FIN_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg <= s_item;
                        case (s_item.kind)
                            KIND_INSERT: begin
                                if (cnt_reg == CNT_W'(CAPACITY)) begin
                                    ign_reg   <= 1'b1;
                                    state_reg <= ST_FIN_RD;
                                end else begin
                                    ign_reg   <= 1'b0;
                                    state_reg <= ST_INS_WR;
                                end
                            end
                            KIND_DELETE_MIN: begin
                                if (cnt_reg == '0) begin
                                    ign_reg   <= 1'b1;
                                    state_reg <= ST_FIN_RD;
                                end else begin
                                    ign_reg   <= 1'b0;
                                    state_reg <= ST_DEL_RD;
                                end
                            end
                            KIND_DECREASE: begin
                                if (CNT_W'(s_item.heap_slot) >= cnt_reg) begin
                                    ign_reg   <= 1'b1;
                                    state_reg <= ST_FIN_RD;
                                end else begin
                                    ign_reg   <= 1'b0;
                                    state_reg <= ST_DEC_RD;
                                end
                            end
                            default: begin
                                ign_reg   <= 1'b1;
                                state_reg <= ST_FIN_RD;
                            end
                        endcase
                    end
                end
                ST_INS_WR: begin
                    cur_reg   <= '{id: in_reg.vertex_id, key: in_reg.key};
                    j_reg     <= last_slot;
                    cnt_reg   <= cnt_reg + CNT_W'(1);
                    state_reg <= (last_slot == '0) ? ST_FIN_RD : ST_UP_RD;
                end
                ST_DEC_RD: begin
                    state_reg <= ST_DEC_WR;
                end
                ST_DEC_WR: begin
                    cur_reg   <= '{id: hp_rd0_reg.id, key: in_reg.key};
                    j_reg     <= in_reg.heap_slot;
                    state_reg <= (in_reg.heap_slot == '0) ? ST_FIN_RD : ST_UP_RD;
                end
                ST_DEL_RD: begin
                    cnt_reg   <= cnt_reg - CNT_W'(1);
                    state_reg <= ST_DEL_WR0;
                end
                ST_DEL_WR0: begin
                    state_reg <= ST_DEL_WR1;
                end
                ST_DEL_WR1: begin
                    cur_reg   <= hp_rd1_reg;
                    j_reg     <= '0;
                    state_reg <= ST_DN_RD;
                end
                ST_UP_RD: begin
                    state_reg <= ST_UP_SW;
                end
                ST_UP_SW: begin
                    oth_reg   <= hp_rd0_reg;
                    nxt_reg   <= up_par;
                    state_reg <= up_swap ? ST_UP_WR1 : ST_FIN_RD;
                end
                ST_UP_WR1: begin
                    j_reg     <= nxt_reg;
                    state_reg <= (nxt_reg == '0) ? ST_FIN_RD : ST_UP_RD;
                end
                ST_DN_RD: begin
                    state_reg <= dn_has_c1 ? ST_DN_SW : ST_FIN_RD;
                end
                ST_DN_SW: begin
                    oth_reg   <= dn_child;
                    nxt_reg   <= dn_caddr;
                    state_reg <= dn_swap ? ST_DN_WR1 : ST_FIN_RD;
                end
                ST_DN_WR1: begin
                    j_reg     <= nxt_reg;
                    state_reg <= ST_DN_RD;
                end
                ST_FIN_RD: begin
                    state_reg <= ST_FIN_OUT;
                end
                ST_FIN_OUT: begin
                    if (out_free) begin
                        m_valid_reg          <= 1'b1;
                        m_item_reg.ignored   <= ign_reg;
                        m_item_reg.empty_res <= (cnt_reg == '0);
                        m_item_reg.min_id    <= (cnt_reg == '0) ? '0 : hp_rd0_reg.id;
                        m_item_reg.min_key   <= (cnt_reg == '0) ? '0 : hp_rd0_reg.key;
                        m_item_reg.count     <= cnt_reg;
                        m_item_reg.id_slot   <= mp_rd_reg;
                        state_reg            <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/imh_checker.sv]
// port-level checks for the indexed min-heap and their bind
`default_nettype none
module imh_checker
    import imh_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire imh_in_t  s_item,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire imh_out_t m_item
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // one item at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.count <= CNT_W'(CAPACITY))
        else $error("count beyond capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.empty_res == (m_item.count == '0))
        else $error("empty flag disagrees with count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.empty_res |-> m_item.min_id == '0 && m_item.min_key == '0)
        else $error("root reported on empty heap");

endmodule

bind indexed_min_heap imh_checker u_imh_checker (.*);
`default_nettype wire

[sim/tb_top.sv]
// testbench for indexed_min_heap: random and directed heap operations checked against a heap tracker
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import imh_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int LONG_HOLD = 400;
    localparam int SETTLE_CYCLES = 60;

    typedef enum {PH_MIX, PH_GROW, PH_SHRINK} phase_e;

    class heap_tracker;
        imh_entry_t entries [CAPACITY];
        logic [SLOT_W-1:0] slot_of [MAX_VERTICES];
        bit id_placed [MAX_VERTICES];
        int unsigned placed_ids[$];
        int unsigned fill;
        imh_out_t due_reports[$];
        int errors;
        int n_insert, n_delete, n_decrease, n_unused, n_dropped, peak_fill;

        function new();
            fill = 0;
            errors = 0;
            n_insert = 0;
            n_delete = 0;
            n_decrease = 0;
            n_unused = 0;
            n_dropped = 0;
            peak_fill = 0;
        endfunction

        function int unsigned fill_level();
            return fill;
        endfunction

        function int outstanding();
            return due_reports.size();
        endfunction

        function logic [ID_W-1:0] any_placed_id();
            return ID_W'(placed_ids[$urandom_range(0, placed_ids.size() - 1)]);
        endfunction

        function void exchange_slots(int unsigned a, int unsigned b);
            imh_entry_t t;
            slot_of[entries[a].id] = SLOT_W'(b);
            slot_of[entries[b].id] = SLOT_W'(a);
            t = entries[a];
            entries[a] = entries[b];
            entries[b] = t;
        endfunction

        function void sift_up(int unsigned j);
            int unsigned up;
            while (j >= 1) begin
                up = (j - 1) / 2;
                if (!(entries[j].key < entries[up].key)) break;
                exchange_slots(j, up);
                j = up;
            end
        endfunction

        function void sift_down(int unsigned j);
            int unsigned c;
            while (2 * j + 1 < fill) begin
                c = 2 * j + 1;
                if (c + 1 < fill && entries[c + 1].key < entries[c].key) c++;
                if (entries[j].key < entries[c].key) break;
                exchange_slots(j, c);
                j = c;
            end
        endfunction

        function void take_op(imh_in_t op);
            imh_out_t want;
            bit dropped;
            dropped = 1'b0;
            case (op.kind)
                KIND_INSERT: begin
                    n_insert++;
                    if (fill >= CAPACITY) begin
                        dropped = 1'b1;
                    end else begin
                        entries[fill].id = op.vertex_id;
                        entries[fill].key = op.key;
                        slot_of[op.vertex_id] = SLOT_W'(fill);
                        if (!id_placed[op.vertex_id]) begin
                            id_placed[op.vertex_id] = 1'b1;
                            placed_ids.push_back(op.vertex_id);
                        end
                        sift_up(fill);
                        fill++;
                    end
                end
                KIND_DELETE_MIN: begin
                    n_delete++;
                    if (fill == 0) begin
                        dropped = 1'b1;
                    end else begin
                        fill--;
                        exchange_slots(0, fill);
                        sift_down(0);
                    end
                end
                KIND_DECREASE: begin
                    n_decrease++;
                    if (op.heap_slot >= fill) begin
                        dropped = 1'b1;
                    end else begin
                        entries[op.heap_slot].key = op.key;
                        sift_up(op.heap_slot);
                    end
                end
                default: begin
                    n_unused++;
                    dropped = 1'b1;
                end
            endcase
            if (dropped) n_dropped++;
            if (fill > peak_fill) peak_fill = fill;
            want.ignored = dropped;
            want.empty_res = (fill == 0);
            want.min_id = (fill > 0) ? entries[0].id : '0;
            want.min_key = (fill > 0) ? entries[0].key : '0;
            want.count = CNT_W'(fill);
            want.id_slot = slot_of[op.vertex_id];
            due_reports.push_back(want);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
            if (want !== seen) begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(imh_out_t seen);
            imh_out_t want;
            if (due_reports.size() == 0) begin
                $error("result item arrived with nothing expected");
                errors++;
                return;
            end
            want = due_reports.pop_front();
            compare_field("ignored", want.ignored, seen.ignored);
            compare_field("empty_res", want.empty_res, seen.empty_res);
            compare_field("min_id", want.min_id, seen.min_id);
            compare_field("min_key", want.min_key, seen.min_key);
            compare_field("count", want.count, seen.count);
            compare_field("id_slot", want.id_slot, seen.id_slot);
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    imh_in_t s_item;
    logic m_valid;
    logic m_ready;
    imh_out_t m_item;

    heap_tracker tracker = new();
    int unsigned cycles = 0;
    int items_offered = 0;
    bit hold_request = 1'b0;

    indexed_min_heap DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $error("no finish within %0d cycles", CYCLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_result(m_item);
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [KEY_BITS-1:0] rand_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 5) return KEY_BITS'($urandom_range(0, 31));
        return KEY_BITS'($urandom);
    endfunction

    function automatic imh_in_t mk(logic [1:0] kind, int vid, logic [KEY_BITS-1:0] key, int slot);
        imh_in_t op;
        op.kind = kind;
        op.vertex_id = ID_W'(vid);
        op.key = key;
        op.heap_slot = SLOT_W'(slot);
        return op;
    endfunction

    function automatic imh_in_t next_op(phase_e ph);
        imh_in_t op;
        int r, w_ins, w_del, w_dec;
        case (ph)
            PH_GROW: begin
                w_ins = 92; w_del = 1; w_dec = 6;
            end
            PH_SHRINK: begin
                w_ins = 1; w_del = 92; w_dec = 6;
            end
            default: begin
                w_ins = 45; w_del = 30; w_dec = 20;
            end
        endcase
        r = $urandom_range(0, 99);
        op.vertex_id = tracker.any_placed_id();
        op.key = rand_key();
        op.heap_slot = SLOT_W'($urandom);
        if (r < w_ins) begin
            op.kind = KIND_INSERT;
            if (tracker.fill_level() < CAPACITY) op.vertex_id = ID_W'($urandom);
        end else if (r < w_ins + w_del) begin
            op.kind = KIND_DELETE_MIN;
        end else if (r < w_ins + w_del + w_dec) begin
            op.kind = KIND_DECREASE;
            if (tracker.fill_level() > 0)
                op.heap_slot = SLOT_W'($urandom_range(0, tracker.fill_level() - 1));
        end else if ($urandom_range(0, 1) == 1) begin
            op.kind = KIND_UNUSED;
        end else begin
            op.kind = KIND_DECREASE;
        end
        return op;
    endfunction

    task automatic offer(input imh_in_t op);
        int gap;
        bit quiet;
        quiet = (items_offered % 400) >= 300;
        gap = (!quiet && $urandom_range(0, 99) < 35) ? idle_len() : 0;
        items_offered++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= op;
        do @(posedge aclk); while (!s_ready);
        tracker.take_op(op);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.outstanding() != 0);
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if ((cycles % 3000) < 2200 && $urandom_range(0, 99) < 30) begin
                m_ready <= 1'b0;
                repeat (idle_len()) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin
        imh_in_t opening[$];
        s_valid = 1'b0;
        s_item = '0;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        opening.push_back(mk(KIND_INSERT, 5, 32'd100, 0));
        opening.push_back(mk(KIND_INSERT, 0, '1, 1023));
        opening.push_back(mk(KIND_INSERT, 1023, '0, 0));
        opening.push_back(mk(KIND_INSERT, 7, '0, 0));
        opening.push_back(mk(KIND_INSERT, 9, 32'd100, 0));
        opening.push_back(mk(KIND_INSERT, 12, 32'd50, 0));
        opening.push_back(mk(KIND_DECREASE, 12, '0, 5));
        opening.push_back(mk(KIND_DECREASE, 9, '1, 1));
        opening.push_back(mk(KIND_DECREASE, 7, '0, 6));
        opening.push_back(mk(KIND_DECREASE, 0, '0, 1023));
        opening.push_back(mk(KIND_UNUSED, 7, '1, 1023));
        opening.push_back(mk(KIND_DELETE_MIN, 1023, '0, 0));
        opening.push_back(mk(KIND_DELETE_MIN, 0, '0, 0));
        opening.push_back(mk(KIND_DELETE_MIN, 5, '0, 0));
        opening.push_back(mk(KIND_DELETE_MIN, 9, '0, 0));
        opening.push_back(mk(KIND_DELETE_MIN, 7, '0, 0));
        opening.push_back(mk(KIND_DELETE_MIN, 12, '0, 0));
        opening.push_back(mk(KIND_DELETE_MIN, 5, '1, 1023));
        opening.push_back(mk(KIND_UNUSED, 0, '0, 0));
        opening.push_back(mk(KIND_DECREASE, 9, '0, 0));
        opening.push_back(mk(KIND_INSERT, 1023, '1, 0));
        foreach (opening[i]) offer(opening[i]);
        wait_drained();

        // receiver holds off while the sender keeps offering
        for (int i = 0; i < 150; i++) begin
            if (i == 40) hold_request = 1'b1;
            offer(next_op(PH_MIX));
        end
        wait_drained();

        while (tracker.fill_level() < CAPACITY) offer(next_op(PH_GROW));
        repeat (6) offer(next_op(PH_GROW));
        while (tracker.fill_level() > 0) offer(next_op(PH_SHRINK));
        repeat (3) offer(next_op(PH_SHRINK));
        repeat (150) offer(next_op(PH_MIX));

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run covered %0d items: %0d inserts, %0d delete-min, %0d decrease-key, %0d unused kind",
                 items_offered, tracker.n_insert, tracker.n_delete, tracker.n_decrease,
                 tracker.n_unused);
        $display("%0d items dropped, heap filled to %0d of %0d entries, %0d mismatches",
                 tracker.n_dropped, tracker.peak_fill, CAPACITY, tracker.errors);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

[indexed_min_heap.f]
rtl/imh_pkg.sv
rtl/indexed_min_heap.sv
rtl/imh_checker.sv
sim/tb_top.sv
